[sv/assert_macros.svh]
// Assertion macros shared by the RTL modules of the statistics block.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[sv/msd_pkg.sv]
// Package for the mean, deviation and standard score block.
// Holds sizes, widths, the back end state type and the queue entry type.
package msd_pkg;
	localparam int MaxItems = 64;
	localparam int IdxW = $clog2(MaxItems);
	localparam int CntW = IdxW + 1;
	localparam int SumW = 14;
	localparam int SqW = 22;

	typedef struct packed {
		logic [CntW-1:0] count;
		logic [SumW-1:0] sum;
		logic [SqW-1:0]  sq;
		logic            dropped;
		logic            bank;
	} set_info_t;

	typedef enum logic [2:0] {
		BE_IDLE, BE_MEAN, BE_ROOT, BE_SDIV, BE_READ, BE_SCORE, BE_EMIT
	} be_state_t;
endpackage

[sv/msd_if.sv]
// Valid/ready channel interface carrying one sample or one result.
// No dependencies.
interface msd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample_value;
	logic       last_item;
	modport source (output valid, sample_value, last_item, input ready);
	modport sink (input valid, sample_value, last_item, output ready);
endinterface

interface msd_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         item_index;
	logic [7:0]         sample_out;
	logic signed [15:0] standard_score;
	logic [13:0]        total;
	logic [15:0]        mean_q;
	logic [14:0]        std_dev_q;
	logic               zero_spread;
	logic               overflow;
	logic               last_result;
	modport source (output valid, item_index, sample_out, standard_score, total, mean_q,
		std_dev_q, zero_spread, overflow, last_result, input ready);
	modport sink (input valid, item_index, sample_out, standard_score, total, mean_q,
		std_dev_q, zero_spread, overflow, last_result, output ready);
endinterface

[sv/msd_front.sv]
// Front end: accepts samples, writes them into one of two store banks and
// accumulates count, sum and sum of squares. Depends on msd_pkg.
`include "assert_macros.svh"
module msd_front (
	input  logic                clk,
	input  logic                arst_n,
	msd_in_if.sink              in_ch,
	input  logic                q_full,
	output logic                q_push,
	output msd_pkg::set_info_t  q_data,
	output logic                wr_en,
	output logic [msd_pkg::IdxW:0] wr_addr,
	output logic [7:0]          wr_data
);
	import msd_pkg::*;

	logic [CntW-1:0] count_q;
	logic [SumW-1:0] sum_q;
	logic [SqW-1:0]  sq_q;
	logic            drop_q;
	logic            bank_q;
	logic            acc;
	logic            room;
	logic [SumW-1:0] sum_n;
	logic [SqW-1:0]  sq_n;
	logic [15:0]     xx;

	assign in_ch.ready = !q_full;
	assign acc = in_ch.valid && in_ch.ready;
	assign room = count_q < CntW'(MaxItems);
	assign xx = 16'(in_ch.sample_value) * 16'(in_ch.sample_value);
	assign sum_n = sum_q + SumW'(in_ch.sample_value);
	assign sq_n = sq_q + SqW'(xx);
	assign wr_en = acc && room;
	assign wr_addr = {bank_q, count_q[IdxW-1:0]};
	assign wr_data = in_ch.sample_value;
	assign q_push = acc && in_ch.last_item;

	always_comb begin
		q_data.count = room ? count_q + CntW'(1) : count_q;
		q_data.sum = room ? sum_n : sum_q;
		q_data.sq = room ? sq_n : sq_q;
		q_data.dropped = drop_q || !room;
		q_data.bank = bank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			drop_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (acc) begin
			if (in_ch.last_item) begin
				count_q <= '0;
				sum_q <= '0;
				sq_q <= '0;
				drop_q <= 1'b0;
				bank_q <= !bank_q;
			end else if (room) begin
				count_q <= count_q + CntW'(1);
				sum_q <= sum_n;
				sq_q <= sq_n;
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	`ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, count_q <= CntW'(MaxItems))
	`ASSERT_NXT(a_last_clr, clk, arst_n, q_push, count_q == '0)
endmodule

[sv/msd_queue.sv]
// Two-entry queue of finished set summaries between front and back ends.
// Depends on msd_pkg.
`include "assert_macros.svh"
module msd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  msd_pkg::set_info_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output msd_pkg::set_info_t head
);
	import msd_pkg::*;

	set_info_t  mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] n_q;

	assign full = n_q == 2'd2;
	assign empty = n_q == 2'd0;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			n_q <= n_q + 2'(push) - 2'(pop);
		end
	end

	`ASSERT_IMP(a_no_ovf, clk, arst_n, push, !full)
	`ASSERT_IMP(a_no_unf, clk, arst_n, pop, !empty)
endmodule

[sv/msd_back.sv]
// Back end: computes mean, deviation and per-sample scores with shared
// iterative divider and square root, reading the sample store. Depends on msd_pkg.
`include "assert_macros.svh"
module msd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  msd_pkg::set_info_t q_head,
	output logic               q_pop,
	input  logic               wr_en,
	input  logic [msd_pkg::IdxW:0] wr_addr,
	input  logic [7:0]         wr_data,
	msd_out_if.source          out_ch
);
	import msd_pkg::*;

	localparam int DivW = 28;
	localparam int DivCW = $clog2(DivW + 1);
	localparam int RootW = 44;
	localparam int RootCW = $clog2(RootW / 2 + 1);

	logic [7:0]       store_q [2*MaxItems];
	logic [7:0]       rd_q;
	be_state_t        st_q, st_n;
	logic [CntW-1:0]  k_q;
	logic [15:0]      mean_q;
	logic [14:0]      sd_q;
	logic [DivW-1:0]  num_q;
	logic [DivW-1:0]  rem_q;
	logic [DivW-1:0]  den_q;
	logic [DivCW-1:0] dcnt_q;
	logic [RootW-1:0] rv_q;
	logic [RootW/2:0] rr_q;
	logic [RootW/2+2:0] rrem_q;
	logic [RootCW-1:0] rcnt_q;
	logic             neg_q;
	logic             ldiv;
	logic [DivW:0]    dtrial;
	logic [RootW/2+2:0] rtrial;
	logic [RootW/2+2:0] rsh;
	logic [35:0]      nq;
	logic [27:0]      ss;
	logic [35:0]      var_d;
	logic [15:0]      xq;
	logic [15:0]      dmag;
	logic [DivW-1:0]  quo;
	logic signed [DivW+1:0] sc;
	logic signed [15:0] sc_sat;
	logic [15:0]      cnt16;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_q <= store_q[{q_head.bank, k_q[IdxW-1:0]}];
	end

	assign cnt16 = 16'(q_head.count);
	assign nq = 36'(q_head.count) * 36'(q_head.sq);
	assign ss = 28'(q_head.sum) * 28'(q_head.sum);
	assign var_d = (nq > 36'(ss)) ? nq - 36'(ss) : '0;
	assign xq = {rd_q, 8'h00};
	assign dmag = (xq >= mean_q) ? xq - mean_q : mean_q - xq;
	assign dtrial = {rem_q, num_q[DivW-1]} - {1'b0, den_q};
	assign rsh = {rrem_q[RootW/2:0], rv_q[RootW-1:RootW-2]};
	assign rtrial = rsh - {rr_q, 2'b01};
	assign quo = num_q;
	assign ldiv = dcnt_q == '0;

	always_comb begin
		if (neg_q) begin
			sc = (DivW+2)'(12800) - $signed({2'b00, quo}) - $signed((DivW+2)'(rem_q != '0));
		end else begin
			sc = (DivW+2)'(12800) + $signed({2'b00, quo});
		end
		if (sd_q == '0) begin
			sc_sat = 16'sd12800;
		end else if (sc > (DivW+2)'(32767)) begin
			sc_sat = 16'sh7fff;
		end else if (sc < -(DivW+2)'(32768)) begin
			sc_sat = -16'sh8000;
		end else begin
			sc_sat = sc[15:0];
		end
	end

	always_comb begin
		st_n = st_q;
		case (st_q)
			BE_IDLE:  if (!q_empty) st_n = BE_MEAN;
			BE_MEAN:  if (ldiv) st_n = BE_ROOT;
			BE_ROOT:  if (rcnt_q == '0) st_n = BE_SDIV;
			BE_SDIV:  if (ldiv) st_n = BE_READ;
			BE_READ:  st_n = BE_SCORE;
			BE_SCORE: if (ldiv) st_n = BE_EMIT;
			BE_EMIT: begin
				if (out_ch.ready) begin
					st_n = (k_q + CntW'(1) == q_head.count) ? BE_IDLE : BE_READ;
				end
			end
			default: st_n = BE_IDLE;
		endcase
	end

	always_comb begin
		out_ch.valid = st_q == BE_EMIT;
		q_pop = (st_q == BE_EMIT) && out_ch.ready && (k_q + CntW'(1) == q_head.count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BE_IDLE;
		end else begin
			st_q <= st_n;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			BE_IDLE: begin
				k_q <= '0;
				num_q <= DivW'({q_head.sum, 8'h00});
				den_q <= DivW'(q_head.count);
				rem_q <= '0;
				dcnt_q <= DivCW'(DivW - 1);
				rv_q <= {var_d[27:0], 16'h0000};
				rr_q <= '0;
				rrem_q <= '0;
				rcnt_q <= RootCW'(RootW / 2 - 1);
			end
			BE_MEAN, BE_SDIV: begin
				num_q <= {num_q[DivW-2:0], !dtrial[DivW]};
				rem_q <= dtrial[DivW] ? {rem_q[DivW-2:0], num_q[DivW-1]} : dtrial[DivW-1:0];
				dcnt_q <= dcnt_q - DivCW'(1);
				if (ldiv && st_q == BE_MEAN) begin
					mean_q <= {num_q[14:0], !dtrial[DivW]};
				end
				if (ldiv && st_q == BE_SDIV) begin
					sd_q <= {num_q[13:0], !dtrial[DivW]};
				end
			end
			BE_SCORE: begin
				if (dcnt_q == DivCW'(DivW)) begin
					num_q <= DivW'(dmag) * DivW'(12'd2560);
					neg_q <= xq < mean_q;
					rem_q <= '0;
				end else begin
					num_q <= {num_q[DivW-2:0], !dtrial[DivW]};
					rem_q <= dtrial[DivW] ? {rem_q[DivW-2:0], num_q[DivW-1]}
						: dtrial[DivW-1:0];
				end
				dcnt_q <= dcnt_q - DivCW'(1);
			end
			BE_ROOT: begin
				rv_q <= {rv_q[RootW-3:0], 2'b00};
				rcnt_q <= rcnt_q - RootCW'(1);
				if (!rtrial[RootW/2+2]) begin
					rrem_q <= rtrial;
					rr_q <= {rr_q[RootW/2-1:0], 1'b1};
				end else begin
					rrem_q <= rsh;
					rr_q <= {rr_q[RootW/2-1:0], 1'b0};
				end
				if (rcnt_q == '0) begin
					num_q <= DivW'(!rtrial[RootW/2+2] ? {rr_q[RootW/2-1:0], 1'b1}
						: {rr_q[RootW/2-1:0], 1'b0});
					den_q <= DivW'(cnt16);
					rem_q <= '0;
					dcnt_q <= DivCW'(DivW - 1);
				end
			end
			BE_READ: begin
				num_q <= '0;
				rem_q <= '0;
				den_q <= DivW'(sd_q);
				dcnt_q <= DivCW'(DivW);
				neg_q <= 1'b0;
			end
			BE_EMIT: begin
				if (out_ch.ready) begin
					k_q <= k_q + CntW'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		out_ch.item_index = k_q[IdxW-1:0];
		out_ch.sample_out = rd_q;
		out_ch.standard_score = sc_sat;
		out_ch.total = q_head.sum;
		out_ch.mean_q = mean_q;
		out_ch.std_dev_q = sd_q;
		out_ch.zero_spread = sd_q == '0;
		out_ch.overflow = q_head.dropped;
		out_ch.last_result = k_q + CntW'(1) == q_head.count;
	end

	`ASSERT_IMP(a_pop_last, clk, arst_n, q_pop, out_ch.last_result)
	`ASSERT_IMP(a_emit_ne, clk, arst_n, out_ch.valid, !q_empty)
	`ASSERT_NXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

[sv/mean_std_dev_standard_score_core.sv]
// Statistics core: mean, population deviation and standard scores of sample sets.
// Loading takes one sample per cycle while fewer than two finished sets wait.
// After the back end takes a set it runs an idle step, the mean division, the square root,
// the deviation division, a sample read and the score division before the first result.
// Each further result repeats the read and score division after the prior is accepted.
// Asynchronous active-low reset clears front counters, queue and state, not the store.
module mean_std_dev_standard_score_core (
	input  logic       clk,
	input  logic       arst_n,
	msd_in_if.sink     in_ch,
	msd_out_if.source  out_ch
);
	import msd_pkg::*;

	logic       q_full, q_empty, q_push, q_pop;
	set_info_t  q_in, q_head;
	logic       wr_en;
	logic [IdxW:0] wr_addr;
	logic [7:0] wr_data;

	msd_front u_front (.clk, .arst_n, .in_ch, .q_full, .q_push, .q_data(q_in),
		.wr_en, .wr_addr, .wr_data);
	msd_queue u_queue (.clk, .arst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
		.full(q_full), .empty(q_empty), .head(q_head));
	msd_back u_back (.clk, .arst_n, .q_empty, .q_head, .q_pop, .wr_en, .wr_addr,
		.wr_data, .out_ch);
endmodule
